[rtl/core/dna_pkg.sv]
// shared types, opcodes and helpers of the dual-number alu
package dna_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned NUM_W     = 81;
  localparam int unsigned MAG_W     = 80;
  localparam int unsigned DEN_W     = 63;
  localparam int unsigned REM_W     = 64;
  localparam int unsigned QSTEPS    = 33;
  localparam int unsigned DIV_LAT   = 36;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_INV  = 3'd4;
  localparam logic [2:0] OP_CONJ = 3'd5;

  typedef enum logic [1:0] {
    KIND_DONE,
    KIND_MUL,
    KIND_DIV,
    KIND_INV
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               zd;
    logic               ovf;
    logic [DW-1:0]      re;
    logic [DW-1:0]      du;
    logic signed [DW-1:0] xa;
    logic signed [DW-1:0] xb;
    logic signed [DW-1:0] ya;
    logic signed [DW-1:0] yb;
  } entry_t;

  typedef struct packed {
    logic          div;
    logic          zd;
    logic          ovf;
    logic [DW-1:0] re;
    logic [DW-1:0] du;
  } meta_t;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  // returns {overflow, saturated value}
  function automatic logic [DW:0] sat32(input logic signed [65:0] v);
    logic [DW:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

endpackage

[rtl/core/dna_if.sv]
// valid/ready channel interfaces for operands and results
interface dna_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic signed [31:0]  x_real;
  logic signed [31:0]  x_dual;
  logic signed [31:0]  y_real;
  logic signed [31:0]  y_dual;

  modport source (output valid, opcode, x_real, x_dual, y_real, y_dual, input ready);
  modport sink (input valid, opcode, x_real, x_dual, y_real, y_dual, output ready);
endinterface

interface dna_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  res_real;
  logic signed [31:0]  res_dual;
  logic                zero_divisor;
  logic                overflow;

  modport source (output valid, res_real, res_dual, zero_divisor, overflow, input ready);
  modport sink (input valid, res_real, res_dual, zero_divisor, overflow, output ready);
endinterface

[rtl/core/dual_number_alu_unit.sv]
// top level of the signed q16.16 dual-number alu
// a result passes through the queue, the product stage, the operand setup stage, the dividers and the result register
// throughput: one transaction per cycle through the pipelined dividers, unless stalled
// the whole execution pipeline holds while the result register waits for ready
// reset: asynchronous active low, clears all valid bits and queue pointers
module dual_number_alu_unit
  import dna_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dna_in_if.sink    in_i,
  dna_out_if.source out_o
);

  logic   push, full, pop, fvalid;
  entry_t push_data, fdata;

  dna_front u_front (
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dna_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (fvalid),
    .data_o      (fdata)
  );

  dna_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fvalid),
    .fifo_data_i  (fdata),
    .fifo_pop_o   (pop),
    .out_o        (out_o)
  );

endmodule

[rtl/core/dna_front.sv]
// front end: accepts operand transactions, computes add, subtract and conjugate results and classifies the rest
module dna_front
  import dna_pkg::*;
(
  dna_in_if.sink   in_i,
  input  logic     full_i,
  output logic     push_o,
  output entry_t   push_data_o
);

  logic [DW:0] s_re;
  logic [DW:0] s_du;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    s_re = '0;
    s_du = '0;
    push_data_o      = '0;
    push_data_o.xa   = in_i.x_real;
    push_data_o.xb   = in_i.x_dual;
    push_data_o.ya   = in_i.y_real;
    push_data_o.yb   = in_i.y_dual;
    push_data_o.kind = KIND_DONE;
    case (in_i.opcode)
      OP_ADD: begin
        s_re = sat32(66'(in_i.x_real) + 66'(in_i.y_real));
        s_du = sat32(66'(in_i.x_dual) + 66'(in_i.y_dual));
      end
      OP_SUB: begin
        s_re = sat32(66'(in_i.x_real) - 66'(in_i.y_real));
        s_du = sat32(66'(in_i.x_dual) - 66'(in_i.y_dual));
      end
      OP_MUL: begin
        push_data_o.kind = KIND_MUL;
      end
      OP_DIV: begin
        if (in_i.y_real == '0) begin
          push_data_o.zd = 1'b1;
          s_du = {1'b0, in_i.y_dual};
        end else begin
          push_data_o.kind = KIND_DIV;
        end
      end
      OP_INV: begin
        if (in_i.x_real == '0) begin
          push_data_o.zd = 1'b1;
        end else begin
          push_data_o.kind = KIND_INV;
        end
      end
      OP_CONJ: begin
        s_re = {1'b0, in_i.x_real};
        s_du = sat32(-66'(in_i.x_dual));
      end
      default: begin
        s_re = '0;
      end
    endcase
    push_data_o.re  = s_re[DW-1:0];
    push_data_o.du  = s_du[DW-1:0];
    push_data_o.ovf = s_re[DW] | s_du[DW];
  end

endmodule

[rtl/core/dna_fifo.sv]
// short queue between front end and execution pipeline
module dna_fifo
  import dna_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  entry_t        mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/dna_div.sv]
// pipelined restoring divider, one quotient bit per stage, saturated signed result
module dna_div
  import dna_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic                    den_neg_i,
  output logic [DW-1:0]           quo_o,
  output logic                    ovf_o
);

  localparam logic [QSTEPS-1:0] NEG_LIM = QSTEPS'(33'h1_0000_0000 >> 1);
  localparam logic [QSTEPS-1:0] POS_LIM = NEG_LIM - QSTEPS'(1);

  logic             neg_a_q;
  logic [MAG_W-1:0] mag_a_q;
  logic [DEN_W-1:0] den_a_q;

  logic [REM_W-1:0]  rem_q [QSTEPS+1];
  logic [QSTEPS-1:0] quo_q [QSTEPS+1];
  logic [QSTEPS-1:0] lo_q  [QSTEPS+1];
  logic [DEN_W-1:0]  den_q [QSTEPS+1];
  logic              big_q [QSTEPS+1];
  logic              neg_q [QSTEPS+1];

  logic [QSTEPS-1:0] q_fin;
  logic              ovf_d;
  logic [DW-1:0]     quo_d;

  // magnitude of the numerator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= num_i[NUM_W-1] ^ den_neg_i;
      mag_a_q <= num_i[NUM_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);
      den_a_q <= den_i;
    end
  end

  // upper bits already at or above the divisor mean a quotient beyond 33 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= REM_W'(mag_a_q[MAG_W-1:QSTEPS]);
      big_q[0] <= REM_W'(mag_a_q[MAG_W-1:QSTEPS]) >= REM_W'(den_a_q);
      quo_q[0] <= '0;
      lo_q[0]  <= mag_a_q[QSTEPS-1:0];
      den_q[0] <= den_a_q;
      neg_q[0] <= neg_a_q;
    end
  end

  for (genvar k = 1; k <= QSTEPS; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;
    assign trial = {rem_q[k-1][REM_W-2:0], lo_q[k-1][QSTEPS-1]};
    assign ge    = trial >= REM_W'(den_q[k-1]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? trial - REM_W'(den_q[k-1]) : trial;
        quo_q[k] <= {quo_q[k-1][QSTEPS-2:0], ge};
        lo_q[k]  <= {lo_q[k-1][QSTEPS-2:0], 1'b0};
        den_q[k] <= den_q[k-1];
        big_q[k] <= big_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign q_fin = quo_q[QSTEPS];

  always_comb begin
    if (neg_q[QSTEPS]) begin
      ovf_d = big_q[QSTEPS] || (q_fin > NEG_LIM);
      quo_d = ovf_d ? 32'h8000_0000 : DW'(-q_fin);
    end else begin
      ovf_d = big_q[QSTEPS] || (q_fin > POS_LIM);
      quo_d = ovf_d ? 32'h7FFF_FFFF : q_fin[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= quo_d;
      ovf_o <= ovf_d;
    end
  end

endmodule

[rtl/core/dna_back.sv]
// execution pipeline: multipliers, operand setup, dividers and result register
module dna_back
  import dna_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fifo_valid_i,
  input  entry_t    fifo_data_i,
  output logic      fifo_pop_o,
  dna_out_if.source out_o
);

  logic adv;

  entry_t             s0_q;
  logic               s0_v_q;
  logic signed [63:0] p_aa_q, p_ab_q, p_ba_q, p_sq_q;
  logic signed [31:0] sq_op;

  logic signed [64:0] mul_sum, diff;
  logic signed [32:0] neg_xb;
  logic [31:0]        abs_xa, abs_ya;
  logic [DW:0]        m_re, m_du;

  meta_t                   meta1_d;
  logic signed [NUM_W-1:0] nr_d, nd_d, nr_q, nd_q;
  logic [DEN_W-1:0]        dr_d, dd_d, dr_q, dd_q;
  logic                    dneg_d, dneg_q;

  meta_t meta_q [DIV_LAT+1];
  logic  v_q    [DIV_LAT+1];

  logic [DW-1:0] qr, qd;
  logic          or_r, or_d;
  meta_t         fin;

  logic          out_v_q;
  logic [DW-1:0] re_q, du_q;
  logic          zd_q, ovf_q;

  assign adv        = !out_v_q || out_o.ready;
  assign fifo_pop_o = adv && fifo_valid_i;
  assign sq_op      = (fifo_data_i.kind == KIND_INV) ? fifo_data_i.xa : fifo_data_i.ya;

  // product stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q   <= fifo_data_i;
      p_aa_q <= fifo_data_i.xa * fifo_data_i.ya;
      p_ab_q <= fifo_data_i.xa * fifo_data_i.yb;
      p_ba_q <= fifo_data_i.xb * fifo_data_i.ya;
      p_sq_q <= sq_op * sq_op;
    end
  end

  // operand setup stage
  assign mul_sum = 65'(p_ab_q) + 65'(p_ba_q);
  assign diff    = 65'(p_ba_q) - 65'(p_ab_q);
  assign neg_xb  = -33'(s0_q.xb);
  assign abs_xa  = s0_q.xa[31] ? 32'(-s0_q.xa) : 32'(s0_q.xa);
  assign abs_ya  = s0_q.ya[31] ? 32'(-s0_q.ya) : 32'(s0_q.ya);
  assign m_re    = sat32(66'(p_aa_q >>> 16));
  assign m_du    = sat32(66'(mul_sum >>> 16));

  always_comb begin
    meta1_d.div = 1'b0;
    meta1_d.zd  = s0_q.zd;
    meta1_d.ovf = s0_q.ovf;
    meta1_d.re  = s0_q.re;
    meta1_d.du  = s0_q.du;
    nr_d   = '0;
    nd_d   = '0;
    dr_d   = '0;
    dd_d   = p_sq_q[DEN_W-1:0];
    dneg_d = 1'b0;
    case (s0_q.kind)
      KIND_MUL: begin
        meta1_d.re  = m_re[DW-1:0];
        meta1_d.du  = m_du[DW-1:0];
        meta1_d.ovf = m_re[DW] | m_du[DW];
      end
      KIND_DIV: begin
        meta1_d.div = 1'b1;
        nr_d   = NUM_W'(s0_q.xa) <<< 16;
        dr_d   = DEN_W'(abs_ya);
        dneg_d = s0_q.ya[31];
        nd_d   = NUM_W'(diff) <<< 16;
      end
      KIND_INV: begin
        meta1_d.div = 1'b1;
        nr_d   = NUM_W'(1) <<< 32;
        dr_d   = DEN_W'(abs_xa);
        dneg_d = s0_q.xa[31];
        nd_d   = NUM_W'(neg_xb) <<< 32;
      end
      default: begin
        meta1_d.div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta1_d;
      nr_q      <= nr_d;
      nd_q      <= nd_d;
      dr_q      <= dr_d;
      dd_q      <= dd_d;
      dneg_q    <= dneg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (adv) begin
      s0_v_q <= fifo_valid_i;
      v_q[0] <= s0_v_q;
    end
  end

  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_pipe
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv) begin
        v_q[k] <= v_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  dna_div u_div_re (
    .clk_i     (clk_i),
    .en_i      (adv),
    .num_i     (nr_q),
    .den_i     (dr_q),
    .den_neg_i (dneg_q),
    .quo_o     (qr),
    .ovf_o     (or_r)
  );

  dna_div u_div_du (
    .clk_i     (clk_i),
    .en_i      (adv),
    .num_i     (nd_q),
    .den_i     (dd_q),
    .den_neg_i (1'b0),
    .quo_o     (qd),
    .ovf_o     (or_d)
  );

  always_comb begin
    fin = meta_q[DIV_LAT];
    if (fin.div) begin
      fin.re  = qr;
      fin.du  = qd;
      fin.ovf = or_r | or_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v_q[DIV_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q  <= fin.re;
      du_q  <= fin.du;
      zd_q  <= fin.zd;
      ovf_q <= fin.ovf;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.res_real     = re_q;
  assign out_o.res_dual     = du_q;
  assign out_o.zero_divisor = zd_q;
  assign out_o.overflow     = ovf_q;

endmodule

[rtl/core/dna_checker.sv]
// port-level checks on the dual-number alu
module dna_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] res_real_i,
  input logic [31:0] res_dual_i,
  input logic        zero_divisor_i,
  input logic        overflow_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(res_real_i) && $stable(res_dual_i)
      && $stable(zero_divisor_i) && $stable(overflow_i))
    else $error("result changed while stalled");

  a_zd_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_divisor_i |-> !overflow_i)
    else $error("zero divisor with overflow");

  a_zd_real_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_divisor_i |-> res_real_i == 32'h0)
    else $error("zero divisor with nonzero real part");

endmodule

bind dual_number_alu_unit dna_port_checks u_dna_port_checks (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .res_real_i     (out_o.res_real),
  .res_dual_i     (out_o.res_dual),
  .zero_divisor_i (out_o.zero_divisor),
  .overflow_i     (out_o.overflow)
);

[dv/dna_checker.sv]
`timescale 1ns / 100ps
// scoreboard for the dual-number alu: predicts each result and compares it
module dna_checker
  import dna_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dna_in_if    in_c,
  dna_out_if   out_c,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] du;
    logic               zd;
    logic               ovf;
  } dual_res_t;

  dual_res_t expected_q[$];

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic dual_res_t predict_dual(input logic [2:0] op,
                                             input logic signed [31:0] xa,
                                             input logic signed [31:0] xb,
                                             input logic signed [31:0] ya,
                                             input logic signed [31:0] yb);
    dual_res_t r;
    logic signed [127:0] wxa, wxb, wya, wyb, num;
    logic ovf;
    wxa = xa;
    wxb = xb;
    wya = ya;
    wyb = yb;
    ovf = 1'b0;
    r.re = '0;
    r.du = '0;
    r.zd = 1'b0;
    case (op)
      OP_ADD: begin
        r.re = clamp32(wxa + wya, ovf);
        r.du = clamp32(wxb + wyb, ovf);
      end
      OP_SUB: begin
        r.re = clamp32(wxa - wya, ovf);
        r.du = clamp32(wxb - wyb, ovf);
      end
      OP_MUL: begin
        r.re = clamp32((wxa * wya) >>> 16, ovf);
        r.du = clamp32((wxa * wyb + wxb * wya) >>> 16, ovf);
      end
      OP_DIV: begin
        if (ya == 0) begin
          r.zd = 1'b1;
          r.du = yb;
        end else begin
          r.re = clamp32((wxa <<< 16) / wya, ovf);
          num = (wxb * wya - wxa * wyb) <<< 16;
          r.du = clamp32(num / (wya * wya), ovf);
        end
      end
      OP_INV: begin
        if (xa == 0) begin
          r.zd = 1'b1;
        end else begin
          num = 128'sd1 <<< 32;
          r.re = clamp32(num / wxa, ovf);
          r.du = clamp32(((-wxb) <<< 32) / (wxa * wxa), ovf);
        end
      end
      OP_CONJ: begin
        r.re = xa;
        r.du = clamp32(-wxb, ovf);
      end
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    dual_res_t want;
    if (rst_ni) begin
      if (in_c.valid && in_c.ready) begin
        expected_q.push_back(predict_dual(in_c.opcode, in_c.x_real, in_c.x_dual,
                                          in_c.y_real, in_c.y_dual));
      end
      if (out_c.valid && out_c.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_c.res_real, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_c.res_real !== want.re) report_mismatch("res_real", out_c.res_real, want.re);
          if (out_c.res_dual !== want.du) report_mismatch("res_dual", out_c.res_dual, want.du);
          if (out_c.zero_divisor !== want.zd) begin
            report_mismatch("zero_divisor", out_c.zero_divisor, want.zd);
          end
          if (out_c.overflow !== want.ovf) report_mismatch("overflow", out_c.overflow, want.ovf);
        end
      end
    end
  end

endmodule

[dv/dual_number_alu_unit_test.sv]
`timescale 1ns / 100ps
// top of the dual-number alu testbench: clock, reset, stimulus and verdict
module dual_number_alu_unit_test;
  import dna_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1530;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   cycle_cnt = 0;
  logic sending_done = 1'b0;

  dna_in_if  in_ch ();
  dna_out_if out_ch ();

  dual_number_alu_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  dna_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_c       (in_ch),
    .out_c      (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.opcode = '0;
    in_ch.x_real = '0;
    in_ch.x_dual = '0;
    in_ch.y_real = '0;
    in_ch.y_dual = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2) == 0 ? 32'h0 : ($urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF);
      3, 4: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      default: return $urandom;
    endcase
  endfunction

  // drives one transaction and returns after it is accepted
  task automatic send_dual(input logic [2:0] op, input logic [31:0] xa,
                           input logic [31:0] xb, input logic [31:0] ya,
                           input logic [31:0] yb);
    int unsigned gap;
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.x_real <= xa;
    in_ch.x_dual <= xb;
    in_ch.y_real <= ya;
    in_ch.y_dual <= yb;
    forever begin
      @(negedge clk_i);
      if (in_ch.ready) break;
    end
    @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    bit calm;
    hold_left = 0;
    mode_left = 0;
    calm = 1'b0;
    @(posedge rst_ni);
    repeat (300) begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
    hold_left = 500;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          calm = ($urandom_range(0, 2) == 0);
          mode_left = $urandom_range(50, 200);
        end
        mode_left--;
        if (calm) out_ch.ready <= 1'b1;
        else if ($urandom_range(0, 30) == 0) begin
          hold_left = $urandom_range(10, 40);
          out_ch.ready <= 1'b0;
        end else out_ch.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  initial begin
    logic [2:0] op;
    logic [31:0] ya;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_dual(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1);
    send_dual(OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
    send_dual(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_dual(OP_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000);
    send_dual(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_dual(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
    send_dual(OP_MUL, 32'h0003_0000, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000);
    send_dual(OP_DIV, 32'h0005_0000, 32'h0001_0000, 32'h0000_0000, 32'h1234_5678);
    send_dual(OP_DIV, 32'h0006_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_dual(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
    send_dual(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_dual(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send_dual(OP_INV, 32'h0000_0000, 32'h7FFF_FFFF, 32'h1, 32'h1);
    send_dual(OP_INV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_dual(OP_INV, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_dual(OP_INV, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0);
    send_dual(OP_INV, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_dual(OP_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0);
    send_dual(OP_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_dual(OP_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_dual(OP_UNUSED_HI, 32'h1, 32'h1, 32'h1, 32'h1);
    repeat (RANDOM_ITEMS) begin
      op = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ya = pick_q();
      if (op == OP_DIV && $urandom_range(0, 7) == 0) ya = '0;
      send_dual(op, pick_q(), pick_q(), ya, pick_q());
    end
    in_ch.valid <= 1'b0;
    sending_done <= 1'b1;
  end

  initial begin
    wait (sending_done);
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
